// ----- rtl/ehd_pkg.sv -----
// Shared types, constants and date helpers for the Easter holiday date calculator.
// Self-contained; used by ehd_computus and easter_holiday_date_calculator.
package ehd_pkg;

  localparam logic [13:0] YEAR_MIN = 14'd1583;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  typedef enum logic [2:0] {
    HC_EASTER         = 3'd0,
    HC_GOOD_FRIDAY    = 3'd1,
    HC_CARNIVAL_START = 3'd2,
    HC_CARNIVAL_END   = 3'd3,
    HC_WHITSUNTIDE    = 3'd4,
    HC_ASCENSION      = 3'd5
  } holiday_code_t;

  // Easter Sunday as a count of days after March 1, plus the leap flag of the year.
  typedef struct packed {
    logic [5:0] march_day;
    logic       leap;
  } easter_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
  } date_t;

  function automatic logic signed [7:0] holiday_offset(holiday_code_t code);
    logic signed [7:0] ofs;
    unique case (code)
      HC_EASTER:         ofs = 8'sd0;
      HC_GOOD_FRIDAY:    ofs = -8'sd2;
      HC_CARNIVAL_START: ofs = -8'sd49;
      HC_CARNIVAL_END:   ofs = -8'sd47;
      HC_WHITSUNTIDE:    ofs = 8'sd49;
      HC_ASCENSION:      ofs = 8'sd39;
      default:           ofs = 8'sd0;
    endcase
    return ofs;
  endfunction

  // All holidays fall between February and June, so the month search is short.
  function automatic date_t holiday_date(easter_t e, holiday_code_t code);
    logic signed [7:0] t;
    logic signed [7:0] s;
    date_t             r;
    t = $signed({2'b00, e.march_day}) + holiday_offset(code);
    priority if (t < 8'sd0) begin
      r.month = 4'd2;
      s = t + (e.leap ? 8'sd30 : 8'sd29);
    end else if (t < 8'sd31) begin
      r.month = 4'd3;
      s = t + 8'sd1;
    end else if (t < 8'sd61) begin
      r.month = 4'd4;
      s = t - 8'sd30;
    end else if (t < 8'sd92) begin
      r.month = 4'd5;
      s = t - 8'sd60;
    end else begin
      r.month = 4'd6;
      s = t - 8'sd91;
    end
    r.day = s[4:0];
    return r;
  endfunction

endpackage

// ----- rtl/ehd_computus.sv -----
// Five-stage elastic pipeline that turns a year into the date of Easter and the leap flag.
// Depends on ehd_pkg for the clamp limits and the easter_t result type.
module ehd_computus import ehd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] year,
  output logic        out_valid,
  input  logic        out_ready,
  output easter_t     easter
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: raw year.
  logic [13:0] yr;
  // Stage 2: a = y mod 19, b = y / 100, c = y mod 100.
  logic [4:0]  s2_a;
  logic [6:0]  s2_b;
  logic [6:0]  s2_c;
  // Stage 3: sum before the mod 30.
  logic [9:0]  s3_hx;
  logic [4:0]  s3_a;
  logic [1:0]  s3_e;
  logic [4:0]  s3_i;
  logic [1:0]  s3_k;
  logic        s3_leap;
  // Stage 4: h.
  logic [4:0]  s4_h;
  logic [4:0]  s4_a;
  logic [1:0]  s4_e;
  logic [4:0]  s4_i;
  logic [1:0]  s4_k;
  logic        s4_leap;
  // Stage 5: h and l.
  logic [4:0]  s5_h;
  logic [2:0]  s5_l;
  logic [4:0]  s5_a;
  logic        s5_leap;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1 to 2: clamp, then divide by 19 and 100 with reciprocal multiply and one correction.
  logic [13:0] y;
  logic [25:0] p19;
  logic [9:0]  q19;
  logic [13:0] r19w;
  logic [5:0]  r19;
  logic [23:0] p100;
  logic [6:0]  q100;
  logic [13:0] r100w;
  logic [7:0]  r100;
  logic [4:0]  a_next;
  logic [6:0]  b_next;
  logic [6:0]  c_next;

  always_comb begin
    if (yr < YEAR_MIN) begin
      y = YEAR_MIN;
    end else if (yr > YEAR_MAX) begin
      y = YEAR_MAX;
    end else begin
      y = yr;
    end
    p19    = 26'(y) * 26'd3449;
    q19    = p19[25:16];
    r19w   = y - 14'(14'd19 * {4'b0000, q19});
    r19    = r19w[5:0];
    a_next = (r19 >= 6'd19) ? 5'(r19 - 6'd19) : r19[4:0];
    p100   = 24'(y) * 24'd655;
    q100   = p100[22:16];
    r100w  = y - 14'(14'd100 * {7'b0000000, q100});
    r100   = r100w[7:0];
    if (r100 >= 8'd100) begin
      b_next = q100 + 7'd1;
      c_next = 7'(r100 - 8'd100);
    end else begin
      b_next = q100;
      c_next = r100[6:0];
    end
  end

  // Stage 2 to 3: century corrections, the epact sum and the leap flag.
  logic [2:0]  f;
  logic [6:0]  gx;
  logic [14:0] pg;
  logic [5:0]  g;
  logic [4:0]  d;
  logic [9:0]  hx_next;
  logic        leap_next;

  always_comb begin
    f = 3'({2'b00, s2_b >= 7'd17} + {2'b00, s2_b >= 7'd42}
           + {2'b00, s2_b >= 7'd67} + {2'b00, s2_b >= 7'd92});
    gx = s2_b - 7'(f) + 7'd1;
    pg = 15'(gx) * 15'd171;
    g  = pg[14:9];
    d  = s2_b[6:2];
    hx_next = 10'd19 * 10'(s2_a) + 10'(s2_b) + 10'd135 - 10'(d) - 10'(g);
    leap_next = (s2_c == 7'd0) ? (s2_b[1:0] == 2'b00) : (s2_c[1:0] == 2'b00);
  end

  // Stage 3 to 4: h = hx mod 30.
  logic [14:0] ph;
  logic [4:0]  qh;
  logic [9:0]  rhw;
  logic [5:0]  rh;
  logic [4:0]  h_next;

  always_comb begin
    ph     = 15'(s3_hx) * 15'd34;
    qh     = ph[14:10];
    rhw    = s3_hx - 10'(10'd30 * {5'b00000, qh});
    rh     = rhw[5:0];
    h_next = (rh >= 6'd30) ? 5'(rh - 6'd30) : rh[4:0];
  end

  // Stage 4 to 5: l = (32 + 2e + 2i + 70 - h - k) mod 7.
  logic [7:0]  lx;
  logic [12:0] pl;
  logic [4:0]  ql;
  logic [7:0]  rlw;
  logic [3:0]  rl;
  logic [2:0]  l_next;

  always_comb begin
    lx     = 8'd102 + {5'b00000, s4_e, 1'b0} + {2'b00, s4_i, 1'b0} - 8'(s4_h) - 8'(s4_k);
    pl     = 13'(lx) * 13'd36;
    ql     = pl[12:8];
    rlw    = lx - 8'(8'd7 * {3'b000, ql});
    rl     = rlw[3:0];
    l_next = (rl >= 4'd7) ? 3'(rl - 4'd7) : rl[2:0];
  end

  // Stage 5 output: month correction m and Easter as days after March 1.
  logic [9:0] mx;
  logic       m;

  always_comb begin
    mx               = 10'(s5_a) + 10'd11 * 10'(s5_h) + 10'd22 * 10'(s5_l);
    m                = (mx >= 10'd451);
    easter.march_day = 6'(6'(s5_h) + 6'(s5_l) + 6'd21 - (m ? 6'd7 : 6'd0));
    easter.leap      = s5_leap;
  end

  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      yr <= year;
    end
    if (rdy2) begin
      s2_a <= a_next;
      s2_b <= b_next;
      s2_c <= c_next;
    end
    if (rdy3) begin
      s3_hx   <= hx_next;
      s3_a    <= s2_a;
      s3_e    <= s2_b[1:0];
      s3_i    <= s2_c[6:2];
      s3_k    <= s2_c[1:0];
      s3_leap <= leap_next;
    end
    if (rdy4) begin
      s4_h    <= h_next;
      s4_a    <= s3_a;
      s4_e    <= s3_e;
      s4_i    <= s3_i;
      s4_k    <= s3_k;
      s4_leap <= s3_leap;
    end
    if (rdy5) begin
      s5_h    <= s4_h;
      s5_l    <= l_next;
      s5_a    <= s4_a;
      s5_leap <= s4_leap;
    end
  end

endmodule

// ----- rtl/easter_holiday_date_calculator.sv -----
// Top level of the Easter holiday date calculator: computus pipeline and result sequencer.
// Depends on ehd_pkg and ehd_computus.
//
// Usage: each request on the slave channel carries one Gregorian year in s_tdata[13:0];
// years outside 1583..9999 are clamped to that range. For every year the master channel
// delivers six results in a fixed order: Easter, Good Friday, carnival start, carnival end,
// Whitsuntide and Ascension. Each result carries the holiday code, day, month and leap flag
// of the year, and m_tlast marks the sixth result.
// The first result of a year is shown once the year has passed the five computus stages and
// the result register. Results leave at one per cycle while m_tready is high and a year is
// ready, six per year, over the single result channel. The five computus stages keep accepting
// years while results are delivered, so up to six years are in flight.
// Reset clears all valid flags; no result is shown until a year is accepted after reset.
// When the receiver holds m_tready low the current result stays on the port unchanged, the
// pipeline fills behind it, and s_tready falls once every stage holds a year.
module easter_holiday_date_calculator import ehd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] year, [15:14] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] holiday_code, [7:3] day_of_month,
                                 // [11:8] month_number, [12] leap_flag, [15:13] zero
  output logic        m_tlast
);

  logic          c_valid;
  logic          c_ready;
  easter_t       c_easter;

  logic          ov;
  holiday_code_t idx;
  easter_t       held;
  date_t         date;

  ehd_computus u_computus (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .year      (s_tdata[13:0]),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .easter    (c_easter)
  );

  assign c_ready = !ov || (m_tready && idx == HC_ASCENSION);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      idx <= HC_EASTER;
    end else if (ov && m_tready && idx != HC_ASCENSION) begin
      idx <= holiday_code_t'(3'(idx + 3'd1));
    end else if (c_ready) begin
      ov  <= c_valid;
      idx <= HC_EASTER;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && c_valid) begin
      held <= c_easter;
    end
  end

  assign date     = holiday_date(held, idx);
  assign m_tvalid = ov;
  assign m_tlast  = (idx == HC_ASCENSION);
  assign m_tdata  = {3'b000, held.leap, date.month, date.day, idx};

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for easter_holiday_date_calculator: sends Gregorian years and
// checks the six dated holiday results of each one against a date predictor kept here.
// Depends on ehd_pkg and the RTL of the block; needs no files or arguments.
module tb;
  import ehd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLIDAY_SHIFT [6] = '{0, -2, -49, -47, 49, 39};

  typedef struct {
    holiday_code_t code;
    logic [4:0]    day;
    logic [3:0]    month;
    logic          leap;
    logic          last;
  } holiday_date_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  holiday_date_t pending_dates[$];
  holiday_date_t want;
  int            mismatches = 0;
  int            stall_cycles = 0;
  int            send_idle_pct = 28;
  int            recv_idle_pct = 55;

  easter_holiday_date_calculator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned month_days(int unsigned mon, bit leap);
    case (mon)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Easter by the anonymous Gregorian computus, then each holiday by walking day by day.
  function automatic void predict_holidays(input logic [13:0] yr);
    int unsigned   y, a, b, c, d, e, f, g, h, i, k, l, m, base, eday, emon, dd, mm;
    int            t;
    bit            leap;
    holiday_code_t hc;
    holiday_date_t r;
    y = 32'(yr);
    if (y < 32'(YEAR_MIN)) y = 32'(YEAR_MIN);
    if (y > 32'(YEAR_MAX)) y = 32'(YEAR_MAX);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    a = y % 19;
    b = y / 100;
    c = y % 100;
    d = b / 4;
    e = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b + 15 + 120 - d - g) % 30;
    i = c / 4;
    k = c % 4;
    l = (32 + 2 * e + 2 * i + 70 - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    base = h + l + 114 - 7 * m;
    eday = base % 31 + 1;
    emon = base / 31;
    hc = hc.first();
    repeat (6) begin
      dd = eday;
      mm = emon;
      t = HOLIDAY_SHIFT[hc];
      while (t > 0) begin
        if (dd < month_days(mm, leap)) begin
          dd++;
        end else begin
          dd = 1;
          mm = (mm >= 12) ? 1 : mm + 1;
        end
        t--;
      end
      while (t < 0) begin
        if (dd > 1) begin
          dd--;
        end else begin
          mm = (mm <= 1) ? 12 : mm - 1;
          dd = month_days(mm, leap);
        end
        t++;
      end
      r.code = hc;
      r.day = dd[4:0];
      r.month = mm[3:0];
      r.leap = leap;
      r.last = (hc == HC_ASCENSION);
      pending_dates.push_back(r);
      hc = hc.next();
    end
  endfunction

  task automatic send_year(input logic [13:0] yr);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, yr};
    do @(posedge clk); while (!s_tready);
    predict_holidays(yr);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result: tdata %h, tlast %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        if (m_tdata[2:0] !== want.code) begin
          $error("holiday_code: expected %0d, got %0d", want.code, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tdata[7:3] !== want.day) begin
          $error("day_of_month: expected %0d, got %0d", want.day, m_tdata[7:3]);
          mismatches++;
        end
        if (m_tdata[11:8] !== want.month) begin
          $error("month_number: expected %0d, got %0d", want.month, m_tdata[11:8]);
          mismatches++;
        end
        if (m_tdata[12] !== want.leap) begin
          $error("leap_flag: expected %0d, got %0d", want.leap, m_tdata[12]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic test_range_clamp();
    send_year(14'd0);
    send_year(14'd1582);
    send_year(14'd1583);
    send_year(14'd9999);
    send_year(14'd10000);
    send_year(14'h3FFF);
  endtask

  // Earliest and latest possible Easter, plus early Easter in a leap year.
  task automatic test_date_extremes();
    send_year(14'd1818);
    send_year(14'd2285);
    send_year(14'd1943);
    send_year(14'd2038);
    send_year(14'd2008);
    send_year(14'd2019);
  endtask

  task automatic test_leap_rules();
    send_year(14'd1600);
    send_year(14'd1900);
    send_year(14'd2000);
    send_year(14'd2024);
    send_year(14'd2100);
  endtask

  task automatic test_bit_patterns();
    send_year(14'h1555);
    send_year(14'h2AAA);
  endtask

  // Mostly valid years, with some below and above the clamped range.
  task automatic test_random_years(input int count);
    int          pick;
    logic [13:0] yr;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 80) yr = 14'($urandom_range(9999, 1583));
      else if (pick < 90) yr = 14'($urandom_range(1582, 0));
      else yr = 14'($urandom_range(16383, 10000));
      send_year(yr);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_range_clamp();
    test_date_extremes();
    test_leap_rules();
    test_bit_patterns();
    test_random_years(37);
    send_idle_pct = 55;
    recv_idle_pct = 28;
    test_random_years(37);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_years(37);
    s_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
